/* rtl/buddy_allocator_fifo_evict_macros.svh */
// assertion macros for the buddy allocator
`ifndef BUDDY_ALLOCATOR_FIFO_EVICT_MACROS_SVH
`define BUDDY_ALLOCATOR_FIFO_EVICT_MACROS_SVH
`ifndef SYNTHESIS
`define BA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/ba_pkg.sv */
// package for the buddy allocator: sizes, codes and states
`default_nettype none
package ba_pkg;
  localparam int TreeLevels = 5;
  localparam int MinBlockLog2 = 7;
  localparam int TotalBytes = 4096;
  localparam int NodeCount = (2 << TreeLevels) - 1;
  localparam int SplitCount = (1 << TreeLevels) - 1;
  localparam int FifoDepth = 1 << TreeLevels;
  localparam int NodeW = $clog2(NodeCount + 1);
  localparam int LvlW = $clog2(TreeLevels + 1);
  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = PtrW + 1;

  typedef logic [1:0] code_t;
  localparam code_t CodeEvict = 2'd0;
  localparam code_t CodeAlloc = 2'd1;
  localparam code_t CodeReject = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_TARGET = 8'b0000_0010,
    ST_SCAN   = 8'b0000_0100,
    ST_SPLIT  = 8'b0000_1000,
    ST_EVICT  = 8'b0001_0000,
    ST_MERGE  = 8'b0010_0000,
    ST_ALLOC  = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } state_t;
endpackage
`default_nettype wire

/* rtl/buddy_allocator_fifo_evict.sv */
// buddy allocator with fifo replacement, one shared node walker
//  channel | ports                                           | direction
//  request | in_valid in_stall in_request_size               | in
//  result  | out_valid out_stall out_result_code             | out
//          | out_block_offset out_block_bytes out_last_result|
// an oversized request is rejected straight from the target step. otherwise the
// sequencer picks the level, scans one node at a time, splits down to the
// target and allocates: a smallest request on an empty tree scans all 63 nodes.
// each eviction adds an issue step, merge steps and a rescan, and a request
// runs at most 32 evictions.
// in_stall is high while a request is in progress, the tree is empty after reset,
// and a held result (out_stall high) freezes the sequencer in place.
`default_nettype none
`include "buddy_allocator_fifo_evict_macros.svh"
module buddy_allocator_fifo_evict (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [12:0] in_request_size,
  output logic             out_valid,
  input  wire logic        out_stall,
  output ba_pkg::code_t    out_result_code,
  output logic [11:0]      out_block_offset,
  output logic [12:0]      out_block_bytes,
  output logic             out_last_result
);
  import ba_pkg::*;

  state_t state_r, state_nxt;
  logic [SplitCount-1:0] split_r;
  logic [NodeCount-1:0] busy_r;
  logic [NodeW-1:0] fifo_mem [FifoDepth];
  logic [PtrW-1:0] head_r;
  logic [CntW-1:0] count_r;
  logic [12:0] size_r;
  logic [12:0] mem_r;
  logic [LvlW-1:0] target_r, lvl_r;
  logic [NodeW-1:0] node_r;
  logic [5:0] evict_k_r;
  logic [NodeW-1:0] rd_node;

  // per-node helpers (node walker looks at node_r only)
  function automatic logic [LvlW-1:0] lvl_of(input logic [NodeW-1:0] n);
    logic [LvlW-1:0] l;
    l = '0;
    for (int i = 1; i <= TreeLevels; i++)
      if ({1'b0, n} >= (NodeW+1)'((1 << i) - 1)) l = LvlW'(i);
    return l;
  endfunction

  function automatic logic [11:0] off_of(input logic [NodeW-1:0] n);
    logic [LvlW-1:0] l;
    logic [NodeW-1:0] pos;
    logic [12:0] o;
    l = lvl_of(n);
    pos = n - NodeW'((1 << l) - 1);
    o = 13'(pos) << (TreeLevels - l);
    return 12'(o << (12 - TreeLevels));
  endfunction

  function automatic logic is_split(input logic [SplitCount-1:0] s,
                                    input logic [NodeW-1:0] n);
    return (n < NodeW'(SplitCount)) ? s[n[PtrW-1:0]] : 1'b0;
  endfunction

  // a node exists when every ancestor is split
  function automatic logic exists(input logic [SplitCount-1:0] s,
                                  input logic [NodeW-1:0] n);
    logic [NodeW-1:0] p;
    logic ok;
    p = n;
    ok = 1'b1;
    for (int i = 0; i < TreeLevels; i++)
      if (p != '0) begin
        p = (p - 1'b1) >> 1;
        if (!is_split(s, p)) ok = 1'b0;
      end
    return ok;
  endfunction

  logic node_free;
  logic [NodeW-1:0] lvl_last;
  logic [NodeW-1:0] parent, sib_a, sib_b;
  logic can_merge;

  assign node_free = exists(split_r, node_r) && !is_split(split_r, node_r) &&
                     !busy_r[node_r];
  assign lvl_last = NodeW'((2 << lvl_r) - 2);
  assign parent = (node_r - 1'b1) >> 1;
  assign sib_a = NodeW'({parent, 1'b1});
  assign sib_b = sib_a + 1'b1;
  assign can_merge = (node_r != '0) && !is_split(split_r, sib_a) &&
                     !is_split(split_r, sib_b) && !busy_r[sib_a] && !busy_r[sib_b];

  always_ff @(posedge clk) begin
    rd_node <= fifo_mem[head_r];
    if (state_r == ST_ALLOC && count_r < CntW'(FifoDepth))
      fifo_mem[PtrW'(head_r + count_r[PtrW-1:0])] <= node_r;
  end

  logic hold;
  assign hold = out_valid && out_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_TARGET;
      ST_TARGET: if (size_r > 13'(TotalBytes)) state_nxt = ST_OUT;
                 else if (!(target_r < LvlW'(TreeLevels) &&
                            mem_r > 13'(1 << MinBlockLog2) &&
                            (mem_r >> 1) >= size_r)) state_nxt = ST_SCAN;
      ST_SCAN:   if (node_free) state_nxt = ST_SPLIT;
                 else if (node_r == lvl_last && lvl_r == '0) state_nxt = ST_EVICT;
      ST_SPLIT:  if (lvl_r == target_r) state_nxt = ST_ALLOC;
      ST_EVICT:  if (!hold) state_nxt = (out_valid && !out_last_result) ? ST_MERGE :
                                       (out_valid ? ST_IDLE : ST_EVICT);
      ST_MERGE:  if (!can_merge) state_nxt = ST_SCAN;
      ST_ALLOC:  state_nxt = ST_OUT;
      ST_OUT:    if (out_valid && !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      split_r <= '0;
      busy_r <= '0;
      head_r <= '0;
      count_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: if (in_valid) begin
          size_r <= in_request_size;
          mem_r <= 13'(TotalBytes);
          target_r <= '0;
          evict_k_r <= '0;
        end
        ST_TARGET: begin
          if (size_r > 13'(TotalBytes)) begin
            out_valid <= 1'b1;
            out_result_code <= CodeReject;
            out_block_offset <= '0;
            out_block_bytes <= '0;
            out_last_result <= 1'b1;
          end else if (state_nxt == ST_SCAN) begin
            lvl_r <= target_r;
            node_r <= NodeW'((1 << target_r) - 1);
          end else begin
            mem_r <= mem_r >> 1;
            target_r <= target_r + 1'b1;
          end
        end
        ST_SCAN: if (!node_free) begin
          if (node_r == lvl_last) begin
            if (lvl_r != '0) begin
              lvl_r <= lvl_r - 1'b1;
              node_r <= NodeW'((1 << (lvl_r - 1'b1)) - 1);
            end
          end else node_r <= node_r + 1'b1;
        end
        ST_SPLIT: if (lvl_r != target_r) begin
          split_r[node_r[PtrW-1:0]] <= 1'b1;
          // both children start free
          busy_r[NodeW'({node_r, 1'b1}) +: 2] <= 2'b00;
          node_r <= NodeW'({node_r, 1'b1});
          lvl_r <= lvl_r + 1'b1;
        end
        ST_EVICT: if (!hold) begin
          if (out_valid) out_valid <= 1'b0;
          else if (count_r == '0 || evict_k_r >= 6'(FifoDepth)) begin
            out_valid <= 1'b1;
            out_result_code <= CodeReject;
            out_block_offset <= '0;
            out_block_bytes <= '0;
            out_last_result <= 1'b1;
          end else begin
            node_r <= (rd_node >= NodeW'(NodeCount)) ? '0 : rd_node;
            busy_r[(rd_node >= NodeW'(NodeCount)) ? '0 : rd_node] <= 1'b0;
            out_valid <= 1'b1;
            out_result_code <= CodeEvict;
            out_block_offset <= off_of((rd_node >= NodeW'(NodeCount)) ? '0 : rd_node);
            out_block_bytes <= 13'(TotalBytes) >>
                               lvl_of((rd_node >= NodeW'(NodeCount)) ? '0 : rd_node);
            out_last_result <= 1'b0;
            head_r <= head_r + 1'b1;
            count_r <= count_r - 1'b1;
            evict_k_r <= evict_k_r + 1'b1;
          end
        end
        ST_MERGE: if (can_merge) begin
          split_r[parent[PtrW-1:0]] <= 1'b0;
          node_r <= parent;
        end else begin
          lvl_r <= target_r;
          node_r <= NodeW'((1 << target_r) - 1);
        end
        ST_ALLOC: begin
          busy_r[node_r] <= 1'b1;
          if (count_r < CntW'(FifoDepth)) count_r <= count_r + 1'b1;
          out_valid <= 1'b1;
          out_result_code <= CodeAlloc;
          out_block_offset <= off_of(node_r);
          out_block_bytes <= 13'(TotalBytes) >> lvl_of(node_r);
          out_last_result <= 1'b1;
        end
        ST_OUT: if (out_valid && !out_stall) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  `BA_ASSERT_IMP(a_busy_stall, clk, rst_n, state_r != ST_IDLE, in_stall)
  `BA_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_r <= CntW'(FifoDepth))
  `BA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                 out_valid && $stable(out_block_offset))
  `BA_ASSERT_IMP(a_idle_quiet, clk, rst_n, state_r == ST_IDLE, !out_valid)
endmodule
`default_nettype wire

/* verif/tb_buddy_allocator_fifo_evict.sv */
// testbench for the buddy allocator: directed table, random requests, predicted results
`default_nettype none
module tb_buddy_allocator_fifo_evict;
  timeunit 1ns;
  timeprecision 1ps;
  import ba_pkg::*;

  localparam int WatchLimit = 20000;

  typedef struct packed {
    code_t       code;
    logic [11:0] offset;
    logic [12:0] bytes;
    logic        last;
  } alloc_res_t;

  typedef struct {
    logic [12:0] size;
    logic        known;
    alloc_res_t  res;
  } req_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [12:0] in_request_size = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  code_t out_result_code;
  logic [11:0] out_block_offset;
  logic [12:0] out_block_bytes;
  logic out_last_result;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  buddy_allocator_fifo_evict i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_request_size(in_request_size),
    .out_valid(out_valid), .out_stall(out_stall), .out_result_code(out_result_code),
    .out_block_offset(out_block_offset), .out_block_bytes(out_block_bytes),
    .out_last_result(out_last_result)
  );

  // predictor state
  logic tree_split [SplitCount];
  logic tree_busy [NodeCount];
  int   order_q [$];
  alloc_res_t pending_q [$];

  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_rx = 1'b0;
  bit done_tx = 1'b0;

  function automatic int node_level(int n);
    int l = 0;
    while (((2 << l) - 1) <= n) l++;
    return l;
  endfunction

  function automatic bit split_at(int n);
    return n < SplitCount && tree_split[n];
  endfunction

  function automatic bit node_present(int n);
    while (n != 0) begin
      n = (n - 1) / 2;
      if (!split_at(n)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic alloc_res_t block_res(code_t c, int n, logic last);
    alloc_res_t r;
    int lv, pos;
    lv = node_level(n);
    pos = n - ((1 << lv) - 1);
    r.code = c;
    r.offset = 12'(pos * (TotalBytes >> lv));
    r.bytes = 13'(TotalBytes >> lv);
    r.last = last;
    return r;
  endfunction

  function automatic void free_and_merge(int n);
    int p;
    tree_busy[n] = 1'b0;
    while (n != 0) begin
      p = (n - 1) / 2;
      if (split_at(2*p+1) || split_at(2*p+2) || tree_busy[2*p+1] || tree_busy[2*p+2])
        return;
      tree_split[p] = 1'b0;
      n = p;
    end
  endfunction

  function automatic int grab_block(int target);
    int first, n;
    for (int l = target; l >= 0; l--) begin
      first = (1 << l) - 1;
      for (n = first; n <= 2*first; n++) begin
        if (node_present(n) && !split_at(n) && !tree_busy[n]) begin
          for (int lv = l; lv < target; lv++) begin
            tree_split[n] = 1'b1;
            tree_busy[2*n+1] = 1'b0;
            tree_busy[2*n+2] = 1'b0;
            n = 2*n + 1;
          end
          return n;
        end
      end
    end
    return NodeCount;
  endfunction

  task automatic predict_alloc(logic [12:0] size);
    int target, mem, n, victim, k;
    alloc_res_t rej;
    rej = '{CodeReject, 12'd0, 13'd0, 1'b1};
    if (size > TotalBytes) begin
      pending_q.push_back(rej);
      return;
    end
    target = 0;
    mem = TotalBytes;
    k = 0;
    while (target < TreeLevels && mem > (1 << MinBlockLog2) && mem / 2 >= size) begin
      mem /= 2;
      target++;
    end
    forever begin
      n = grab_block(target);
      if (n < NodeCount) break;
      if (order_q.size() == 0 || k >= FifoDepth) begin
        pending_q.push_back(rej);
        return;
      end
      victim = order_q.pop_front();
      pending_q.push_back(block_res(CodeEvict, victim, 1'b0));
      k++;
      free_and_merge(victim);
    end
    tree_busy[n] = 1'b1;
    if (order_q.size() < FifoDepth) order_q.push_back(n);
    pending_q.push_back(block_res(CodeAlloc, n, 1'b1));
  endtask

  // directed table; known rows carry a result readable at a glance
  req_row_t dir_rows [$];
  function automatic void add_row(logic [12:0] s, logic k, alloc_res_t r);
    req_row_t row;
    row.size = s; row.known = k; row.res = r;
    dir_rows.push_back(row);
  endfunction

  task automatic send_req(logic [12:0] size);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_request_size <= size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_alloc(size);
    @(negedge clk);
  endtask

  function automatic logic [12:0] rand_size();
    case ($urandom_range(0, 9))
      0: return 13'($urandom_range(4097, 8191));
      1: return 13'($urandom);
      2: return 13'($urandom_range(1025, 4096));
      3, 4: return 13'($urandom_range(0, 1024));
      default: return 13'($urandom_range(0, 300));
    endcase
  endfunction

  // stimulus
  initial begin
    alloc_res_t checked;
    for (int i = 0; i < SplitCount; i++) tree_split[i] = 1'b0;
    for (int i = 0; i < NodeCount; i++) tree_busy[i] = 1'b0;
    add_row(13'd8191, 1'b1, '{CodeReject, 12'd0, 13'd0, 1'b1});
    add_row(13'd4097, 1'b1, '{CodeReject, 12'd0, 13'd0, 1'b1});
    add_row(13'd0, 1'b1, '{CodeAlloc, 12'd0, 13'd128, 1'b1});
    add_row(13'd128, 1'b0, '0);
    add_row(13'd129, 1'b0, '0);
    add_row(13'd4096, 1'b0, '0);
    add_row(13'd1, 1'b0, '0);
    add_row(13'd2048, 1'b0, '0);
    add_row(13'd2049, 1'b0, '0);
    add_row(13'd1024, 1'b0, '0);
    add_row(13'd5000, 1'b1, '{CodeReject, 12'd0, 13'd0, 1'b1});
    for (int i = 0; i < 12; i++) add_row(13'd100, 1'b0, '0);
    add_row(13'd4096, 1'b0, '0);
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].size);
      if (dir_rows[i].known) begin
        checked = pending_q[pending_q.size() - 1];
        if (checked != dir_rows[i].res) begin
          $error("table row %0d result: expected %h, got %h", i, dir_rows[i].res,
                 checked);
          errors++;
        end
      end
    end
    for (int i = 0; i < 480; i++) begin
      if (i == 150) begin
        // hold the sender until the block has drained
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
      end
      if (i == 200) hold_rx = 1'b1;
      if (i == 420) quiet = 1'b1;
      send_req(rand_size());
    end
    in_valid <= 1'b0;
    done_tx = 1'b1;
  end

  // receiver idling
  initial begin
    int gap;
    out_stall <= 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        hold_rx = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 7);
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    alloc_res_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          $error("result with no request pending: code %0d", out_result_code);
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (out_result_code !== want.code) begin
            $error("result_code: expected %0d, got %0d", want.code, out_result_code);
            errors++;
          end
          if (out_block_offset !== want.offset) begin
            $error("block_offset: expected %0d, got %0d", want.offset, out_block_offset);
            errors++;
          end
          if (out_block_bytes !== want.bytes) begin
            $error("block_bytes: expected %0d, got %0d", want.bytes, out_block_bytes);
            errors++;
          end
          if (out_last_result !== want.last) begin
            $error("last_result: expected %0d, got %0d", want.last, out_last_result);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (idle_cycles >= WatchLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    wait (done_tx);
    while (pending_q.size() != 0) @(negedge clk);
    repeat (500) @(negedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
+incdir+rtl
rtl/ba_pkg.sv
rtl/buddy_allocator_fifo_evict.sv
verif/tb_buddy_allocator_fifo_evict.sv
